// File: hw/rtl/cdfr_pkg.sv
// ----------------------------------------------------------------------------
// cdfr_pkg
// Shared types and constants of the download/calibration frame receiver:
// transfer structs, input kinds, event codes, frame bytes, acknowledge codes, phase codes and window geometry.
// ----------------------------------------------------------------------------
package cdfr_pkg;

    // Default width of the calibrated channel mask
    localparam int CDFR_MASK_BITS = 16;

    // Input kinds
    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_DL_SVC  = 2'd1;
    localparam logic [1:0] KIND_CAL_SVC = 2'd2;

    // Event codes
    localparam logic [3:0] EV_NONE       = 4'd0;
    localparam logic [3:0] EV_PAYLOAD    = 4'd1;
    localparam logic [3:0] EV_START_ACK  = 4'd2;
    localparam logic [3:0] EV_HEADER     = 4'd3;
    localparam logic [3:0] EV_SECT_DONE  = 4'd4;
    localparam logic [3:0] EV_CAL_ENTER  = 4'd5;
    localparam logic [3:0] EV_CAL_CHAN   = 4'd6;
    localparam logic [3:0] EV_CAL_DONE   = 4'd7;
    localparam logic [3:0] EV_IGNORED    = 4'd8;

    // Frame bytes
    localparam logic [7:0] B_START_SYNC = 8'hAF;
    localparam logic [7:0] B_SYNC       = 8'hAA;
    localparam logic [7:0] B_START_END  = 8'hFA;
    localparam logic [7:0] B_TRAIL      = 8'hCC;
    localparam logic [7:0] B_CAL_ENTER  = 8'h33;
    localparam logic [7:0] B_CAL_CHAN   = 8'h55;
    localparam logic [7:0] B_EXIT0      = 8'hC3;
    localparam logic [7:0] B_EXIT1      = 8'h3C;
    localparam logic [7:0] B_EXIT2      = 8'hFF;

    // Acknowledge codes
    localparam logic [7:0] ACK_ENTER = 8'h55;
    localparam logic [7:0] ACK_EXIT  = 8'hFF;

    // Phase codes: 2n-1 header of section n, 2n payload of section n
    localparam logic [3:0] PH_IDLE         = 4'd0;
    localparam logic [3:0] PH_FIRST_HEADER = 4'd1;
    localparam logic [3:0] PH_FIRST_PAYLD  = 4'd2;
    localparam logic [3:0] PH_LAST_PAYLD   = 4'd8;

    // Window geometry
    localparam int WIN_DEPTH = 8;
    localparam int HDR_CHECK = 5;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_value;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  event_res;
        logic [2:0]  section;
        logic [15:0] offset;
        logic [7:0]  data_byte;
        logic [15:0] length;
        logic [7:0]  ack_code;
        logic [15:0] channel_mask;
        logic        download_done;
    } t_out_item;

endpackage

// File: hw/rtl/cdfr_core.sv
// ----------------------------------------------------------------------------
// cdfr_core
// Frame recognition state and per-item step logic. One item is consumed per
// accepted transfer; the result is produced combinationally from the current
// state and the item, and the state is updated at the same edge.
// ----------------------------------------------------------------------------
module cdfr_core
    import cdfr_pkg::*;
#(
    parameter int MASK_BITS = CDFR_MASK_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    output t_out_item o_result
);

    logic [3:0]           r_phase,      n_phase;
    logic [16:0]          r_byte_index, n_byte_index;
    logic [7:0]           r_store [WIN_DEPTH];
    logic [7:0]           n_store [WIN_DEPTH];
    logic [15:0]          r_sec_len,    n_sec_len;
    logic                 r_calib_mode, n_calib_mode;
    logic                 r_calib_done, n_calib_done;
    logic                 r_dl_done,    n_dl_done;
    logic [MASK_BITS-1:0] r_chan,       n_chan;

    logic [7:0]           st_wr [WIN_DEPTH];
    logic [16:0]          idx_inc;
    logic [MASK_BITS-1:0] chan_hit;
    logic [3:0]           hdr_sec;
    logic                 is_header;
    logic                 is_payload;
    logic [16:0]          payload_end;
    logic [31:0]          chan_ext;

    logic [3:0]  ev;
    logic [2:0]  sec;
    logic [15:0] off;
    logic [7:0]  dat;
    logic [15:0] len;
    logic [7:0]  ack;

    // Window with the incoming byte written at the current index
    always_comb begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
            st_wr[i] = r_store[i];
        end
        if (r_byte_index < 17'(WIN_DEPTH)) begin
            st_wr[r_byte_index[2:0]] = i_item.byte_value;
        end
    end

    assign idx_inc     = r_byte_index + 17'd1;
    assign hdr_sec     = 4'(r_phase + 4'd1) >> 1;
    assign is_header   = (r_phase >= PH_FIRST_HEADER) && (r_phase <= PH_LAST_PAYLD) &&
                         r_phase[0];
    assign is_payload  = (r_phase >= PH_FIRST_PAYLD) && (r_phase <= PH_LAST_PAYLD);
    assign payload_end = {1'b0, r_sec_len} + 17'(WIN_DEPTH);

    // Decode the channel number of a channel frame
    always_comb begin
        for (int i = 0; i < MASK_BITS; i++) begin
            chan_hit[i] = (st_wr[2] == 8'(i));
        end
    end

    // Step: next state and result of one item
    always_comb begin
        n_phase      = r_phase;
        n_byte_index = r_byte_index;
        for (int i = 0; i < WIN_DEPTH; i++) begin
            n_store[i] = r_store[i];
        end
        n_sec_len    = r_sec_len;
        n_calib_mode = r_calib_mode;
        n_calib_done = r_calib_done;
        n_dl_done    = r_dl_done;
        n_chan       = r_chan;
        ev  = EV_NONE;
        sec = 3'd0;
        off = 16'd0;
        dat = 8'd0;
        len = 16'd0;
        ack = 8'd0;

        unique case (i_item.kind)
            KIND_DL_SVC: begin
                if (r_dl_done) begin
                    n_dl_done = 1'b0;
                    n_phase   = PH_IDLE;
                end
            end
            KIND_CAL_SVC: begin
                if (r_calib_done) begin
                    n_calib_mode = 1'b0;
                    n_calib_done = 1'b0;
                end
            end
            KIND_BYTE: begin
                if (r_dl_done) begin
                    // Drop bytes until the finished download is serviced
                    ev = EV_IGNORED;
                end else if (r_calib_mode) begin
                    n_store      = st_wr;
                    n_byte_index = idx_inc;
                    if (st_wr[0] == B_SYNC && st_wr[1] == B_CAL_CHAN &&
                        st_wr[7] == B_TRAIL) begin
                        n_chan = r_chan | chan_hit;
                        ev     = EV_CAL_CHAN;
                        ack    = st_wr[2];
                        for (int i = 0; i < WIN_DEPTH; i++) n_store[i] = 8'd0;
                        n_byte_index = 17'd0;
                    end else if (st_wr[0] == B_EXIT0 && st_wr[1] == B_EXIT1 &&
                                 st_wr[2] == B_EXIT2 && st_wr[7] == B_TRAIL) begin
                        n_calib_done = 1'b1;
                        ev           = EV_CAL_DONE;
                        ack          = ACK_EXIT;
                        for (int i = 0; i < WIN_DEPTH; i++) n_store[i] = 8'd0;
                        n_byte_index = 17'd0;
                    end else if (idx_inc >= 17'(WIN_DEPTH)) begin
                        for (int i = 0; i < WIN_DEPTH; i++) n_store[i] = 8'd0;
                        n_byte_index = 17'd0;
                    end
                end else if (is_header) begin
                    sec = hdr_sec[2:0];
                    if (r_byte_index == 17'd0 && i_item.byte_value != B_SYNC) begin
                        // Hold the stray byte in the first slot, keep hunting
                        n_store[0] = i_item.byte_value;
                    end else begin
                        n_store      = st_wr;
                        n_byte_index = idx_inc;
                        if (idx_inc >= 17'(HDR_CHECK)) begin
                            if (st_wr[0] == B_SYNC && st_wr[1] == {4'd0, hdr_sec} &&
                                st_wr[4] == B_TRAIL) begin
                                n_sec_len = {st_wr[2], st_wr[3]};
                                n_phase   = r_phase + 4'd1;
                                ev        = EV_HEADER;
                                len       = {st_wr[2], st_wr[3]};
                            end else begin
                                n_byte_index = 17'd0;
                            end
                        end
                    end
                end else if (is_payload) begin
                    sec = r_phase[3:1];
                    len = r_sec_len;
                    if (r_byte_index >= 17'(WIN_DEPTH)) begin
                        ev  = EV_PAYLOAD;
                        off = 16'(r_byte_index - 17'(WIN_DEPTH));
                        dat = i_item.byte_value;
                    end
                    n_store      = st_wr;
                    n_byte_index = idx_inc;
                    // Commit the section on its last byte
                    if (idx_inc >= payload_end) begin
                        ev = EV_SECT_DONE;
                        for (int i = 0; i < WIN_DEPTH; i++) n_store[i] = 8'd0;
                        n_byte_index = 17'd0;
                        n_sec_len    = 16'd0;
                        if (r_phase == PH_LAST_PAYLD) begin
                            n_phase   = PH_IDLE;
                            n_dl_done = 1'b1;
                        end else begin
                            n_phase = r_phase + 4'd1;
                        end
                    end
                end else begin
                    n_store      = st_wr;
                    n_byte_index = idx_inc;
                    if (st_wr[0] == B_START_SYNC && st_wr[1] == B_SYNC &&
                        st_wr[6] == B_START_END) begin
                        n_phase = PH_FIRST_HEADER;
                        ev      = EV_START_ACK;
                        for (int i = 0; i < WIN_DEPTH; i++) n_store[i] = 8'd0;
                        n_byte_index = 17'd0;
                    end else if (st_wr[0] == B_SYNC && st_wr[1] == B_TRAIL &&
                                 st_wr[2] == B_CAL_ENTER && st_wr[7] == B_TRAIL) begin
                        n_calib_mode = 1'b1;
                        ev           = EV_CAL_ENTER;
                        ack          = ACK_ENTER;
                        for (int i = 0; i < WIN_DEPTH; i++) n_store[i] = 8'd0;
                        n_byte_index = 17'd0;
                    end else if (idx_inc >= 17'(WIN_DEPTH)) begin
                        for (int i = 0; i < WIN_DEPTH; i++) n_store[i] = 8'd0;
                        n_byte_index = 17'd0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Pack the result
    assign chan_ext = 32'(n_chan);

    always_comb begin
        o_result.event_res     = ev;
        o_result.section       = sec;
        o_result.offset        = off;
        o_result.data_byte     = dat;
        o_result.length        = len;
        o_result.ack_code      = ack;
        o_result.channel_mask  = chan_ext[15:0];
        o_result.download_done = n_dl_done;
    end

    // Advance state on each accepted transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_byte_index <= 17'd0;
            for (int i = 0; i < WIN_DEPTH; i++) r_store[i] <= 8'd0;
            r_sec_len    <= 16'd0;
            r_calib_mode <= 1'b0;
            r_calib_done <= 1'b0;
            r_dl_done    <= 1'b0;
            r_chan       <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_byte_index <= n_byte_index;
            r_store      <= n_store;
            r_sec_len    <= n_sec_len;
            r_calib_mode <= n_calib_mode;
            r_calib_done <= n_calib_done;
            r_dl_done    <= n_dl_done;
            r_chan       <= n_chan;
        end
    end

    // A finished download parks the sequencer in idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dl_done |-> (r_phase == PH_IDLE))
        else $error("download done outside idle phase");

    // Calibration and download never run together
    a_calib_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_calib_mode |-> (r_phase == PH_IDLE))
        else $error("calibration mode during download");

    // Calibration can only finish while in calibration mode
    a_calib_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_calib_done |-> r_calib_mode)
        else $error("calibration done without calibration mode");

    // The idle and calibration windows never overrun
    a_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_byte_index < 17'(WIN_DEPTH)))
        else $error("frame window index overrun");

endmodule

// File: hw/rtl/cdfr_out_buf.sv
// ----------------------------------------------------------------------------
// cdfr_out_buf
// Two-entry result buffer. Keeps the input side taking one transfer per cycle
// while a result waits on a stalled output, until both entries are full.
// ----------------------------------------------------------------------------
module cdfr_out_buf
    import cdfr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_item i_data,
    output logic      o_full,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    t_out_item  r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign pop     = o_valid && !i_stall;
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_mem[r_rd_ptr];

    // Store the incoming result
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Track pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= !r_wr_ptr;
            if (pop)    r_rd_ptr <= !r_rd_ptr;
            r_count <= r_count + 2'(i_push) - 2'(pop);
        end
    end

    // Occupancy stays within the two entries
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("result buffer occupancy overflow");

endmodule

// File: hw/rtl/config_download_frame_receiver.sv
// ----------------------------------------------------------------------------
// config_download_frame_receiver
// Receives serial bytes and service events, recognizes start, section header
// and calibration frames, and reports one result per input transfer.
// ----------------------------------------------------------------------------
// Each input transfer yields exactly one result transfer. The block takes one
// transfer per clock: the frame state is updated at the accepting edge, and
// results go into a two-entry output buffer, so the input stalls only when
// both entries hold results not yet taken. A result is written into the
// output buffer at the accepting edge and leaves it after any earlier results.
// No clearing pass is needed after reset.
module config_download_frame_receiver
    import cdfr_pkg::*;
#(
    parameter int MASK_BITS = CDFR_MASK_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic      in_accept;
    logic      buf_full;
    t_out_item step_result;

    assign o_in_stall = buf_full;
    assign in_accept  = i_in_valid && !buf_full;

    // Frame recognition and state
    cdfr_core #(
        .MASK_BITS (MASK_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (in_accept),
        .i_item   (i_in_data),
        .o_result (step_result)
    );

    // Result buffer toward the output channel
    cdfr_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_data  (step_result),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule
